// File: rtl/core/plt_pkg.sv
// Shared types and constants of the packed list table.
package plt_pkg;

  // Field widths
  localparam int OP_W  = 3;
  localparam int POS_W = 8;
  localparam int OUT_W = 64;
  localparam int CNT_W = 9;
  localparam int ST_W  = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
  localparam logic [OP_W-1:0] OP_GET      = 3'd2;
  localparam logic [OP_W-1:0] OP_SET      = 3'd3;
  localparam logic [OP_W-1:0] OP_CONTAINS = 3'd4;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

  // Datapath commands issued by the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_APPEND,
    CMD_READ_POS,
    CMD_RD_DONE,
    CMD_SCAN_START,
    CMD_SCAN,
    CMD_SHIFT,
    CMD_OUT_LOAD
  } cmd_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            pos_ok;
    logic            scan_hit;
    logic            scan_miss;
    logic            shift_end;
  } sts_t;

endpackage

// File: rtl/core/packed_list_table.sv
// Top level of the packed list table: controller and datapath.
//
//  channel   direction  handshake            payload
//  in_       request    in_valid/in_stall    in_op, in_position, in_element_value
//  out_      result     out_valid/out_stall  out_status, out_read_value, out_found,
//                                            out_entry_count
//
// One request at a time. Append and out-of-range get/set go from execute to the
// finish state; in-range get/set pass a read state first. Contains and remove
// walk the stored entries one per cycle through the single memory read port:
// contains scans to a match or the end, remove scans, then shifts later entries.
// Synchronous active-low reset clears count and control; the entry memory is not
// cleared, so no clearing pass runs. A new request is taken while a result still
// waits in the output register; a stalled output only delays the next result.
module packed_list_table #(
  parameter int CAPACITY  = 256,
  parameter int WORD_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [plt_pkg::OP_W-1:0]    in_op,
  input  logic [plt_pkg::POS_W-1:0]   in_position,
  input  logic [plt_pkg::OUT_W-1:0]   in_element_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [plt_pkg::ST_W-1:0]    out_status,
  output logic [plt_pkg::OUT_W-1:0]   out_read_value,
  output logic                        out_found,
  output logic [plt_pkg::CNT_W-1:0]   out_entry_count
);

  plt_pkg::cmd_t cmd;
  plt_pkg::sts_t sts;

  // Sequence each request
  plt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Hold the list and build results
  plt_dpath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_op),
    .in_position      (in_position),
    .in_element_value (in_element_value),
    .out_status       (out_status),
    .out_read_value   (out_read_value),
    .out_found        (out_found),
    .out_entry_count  (out_entry_count)
  );

endmodule

// File: rtl/core/plt_ctrl.sv
// Controller state machine of the packed list table.
module plt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output plt_pkg::cmd_t cmd,
  input  plt_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Output register is free when empty or being taken this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign out_valid = out_valid_r;

  // Next state and command
  always_comb begin
    state_nxt     = state_r;
    cmd           = plt_pkg::CMD_NONE;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = plt_pkg::CMD_LATCH;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          plt_pkg::OP_APPEND: begin
            cmd       = plt_pkg::CMD_APPEND;
            state_nxt = S_FIN;
          end
          plt_pkg::OP_GET, plt_pkg::OP_SET: begin
            cmd       = plt_pkg::CMD_READ_POS;
            state_nxt = sts.pos_ok ? S_RD : S_FIN;
          end
          plt_pkg::OP_REMOVE, plt_pkg::OP_CONTAINS: begin
            cmd       = plt_pkg::CMD_SCAN_START;
            state_nxt = S_SCAN;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_RD: begin
        cmd       = plt_pkg::CMD_RD_DONE;
        state_nxt = S_FIN;
      end
      S_SCAN: begin
        cmd = plt_pkg::CMD_SCAN;
        if (sts.scan_hit) begin
          state_nxt = (sts.op == plt_pkg::OP_REMOVE) ? S_SHIFT : S_FIN;
        end else if (sts.scan_miss) begin
          state_nxt = S_FIN;
        end
      end
      S_SHIFT: begin
        cmd = plt_pkg::CMD_SHIFT;
        if (sts.shift_end) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd           = plt_pkg::CMD_OUT_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An accepted request always starts execution next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EXEC))
    else $error("accepted request did not start execution");

  // A finished result waits while the output register is stalled
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && out_stall) |=> (state_r == S_FIN && out_valid_r))
    else $error("result overwrote a stalled output");

  // A stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled result dropped");

endmodule

// File: rtl/core/plt_dpath.sv
// Datapath of the packed list table: entry memory, count, scan and shift pointers.
module plt_dpath #(
  parameter int CAPACITY  = 256,
  parameter int WORD_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  plt_pkg::cmd_t               cmd,
  output plt_pkg::sts_t               sts,
  input  logic [plt_pkg::OP_W-1:0]    in_op,
  input  logic [plt_pkg::POS_W-1:0]   in_position,
  input  logic [plt_pkg::OUT_W-1:0]   in_element_value,
  output logic [plt_pkg::ST_W-1:0]    out_status,
  output logic [plt_pkg::OUT_W-1:0]   out_read_value,
  output logic                        out_found,
  output logic [plt_pkg::CNT_W-1:0]   out_entry_count
);

  localparam int LIMIT = (CAPACITY < 511) ? CAPACITY : 511;
  localparam int AW    = $clog2(LIMIT);
  localparam int CW    = plt_pkg::CNT_W;
  localparam int OW    = plt_pkg::OUT_W;
  localparam logic [CW-1:0] LIMIT_C = CW'(LIMIT);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  logic [WORD_BITS-1:0] mem [LIMIT];

  logic [plt_pkg::OP_W-1:0]  op_r;
  logic [plt_pkg::POS_W-1:0] pos_r;
  logic [WORD_BITS-1:0]      word_r;
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             idx_r;
  logic [CW-1:0]             wp_r;
  logic                      vld_r;
  logic [WORD_BITS-1:0]      rdata_r;
  logic [plt_pkg::ST_W-1:0]  st_status_r;
  logic [WORD_BITS-1:0]      st_rd_r;
  logic                      st_found_r;
  logic [plt_pkg::ST_W-1:0]  out_status_r;
  logic [WORD_BITS-1:0]      out_rd_r;
  logic                      out_found_r;
  logic [CW-1:0]             out_count_r;

  logic [CW-1:0]        pos_ext;
  logic                 pos_ok;
  logic                 idx_more;
  logic                 has_room;
  logic                 hit;
  logic                 drained;
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        wa;
  logic [AW-1:0]        ra;
  logic [WORD_BITS-1:0] wd;

  // Decode conditions from held state
  assign pos_ext  = {1'b0, pos_r};
  assign pos_ok   = pos_ext < count_r;
  assign idx_more = idx_r < count_r;
  assign has_room = count_r < LIMIT_C;
  assign hit      = vld_r && (rdata_r == word_r);
  assign drained  = !vld_r && !idx_more;

  assign sts.op        = op_r;
  assign sts.pos_ok    = pos_ok;
  assign sts.scan_hit  = hit;
  assign sts.scan_miss = drained;
  assign sts.shift_end = drained;

  // Memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    wa     = count_r[AW-1:0];
    ra     = idx_r[AW-1:0];
    wd     = word_r;
    case (cmd)
      plt_pkg::CMD_APPEND: begin
        mem_we = has_room;
      end
      plt_pkg::CMD_READ_POS: begin
        mem_re = pos_ok;
        ra     = pos_ext[AW-1:0];
      end
      plt_pkg::CMD_RD_DONE: begin
        mem_we = (op_r == plt_pkg::OP_SET);
        wa     = pos_ext[AW-1:0];
      end
      plt_pkg::CMD_SCAN: begin
        mem_re = idx_more;
      end
      plt_pkg::CMD_SHIFT: begin
        mem_re = idx_more;
        mem_we = vld_r;
        wa     = wp_r[AW-1:0];
        wd     = rdata_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Entry memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wa] <= wd;
    end
    if (mem_re) begin
      rdata_r <= mem[ra];
    end
  end

  // Count, walk pointer and read-pending flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      vld_r   <= 1'b0;
    end else begin
      case (cmd)
        plt_pkg::CMD_LATCH, plt_pkg::CMD_SCAN_START: begin
          idx_r <= '0;
          vld_r <= 1'b0;
        end
        plt_pkg::CMD_APPEND: begin
          if (has_room) begin
            count_r <= count_r + ONE_C;
          end
        end
        plt_pkg::CMD_SCAN: begin
          vld_r <= idx_more;
          if (idx_more) begin
            idx_r <= idx_r + ONE_C;
          end
        end
        plt_pkg::CMD_SHIFT: begin
          vld_r <= idx_more;
          if (idx_more) begin
            idx_r <= idx_r + ONE_C;
          end
          if (drained) begin
            count_r <= count_r - ONE_C;
          end
        end
        default: begin
          vld_r <= vld_r;
        end
      endcase
    end
  end

  // Request fields, result staging and output register
  always_ff @(posedge clk) begin
    case (cmd)
      plt_pkg::CMD_LATCH: begin
        op_r        <= in_op;
        pos_r       <= in_position;
        word_r      <= in_element_value[WORD_BITS-1:0];
        st_status_r <= plt_pkg::ST_OK;
        st_rd_r     <= '0;
        st_found_r  <= 1'b0;
      end
      plt_pkg::CMD_APPEND: begin
        if (!has_room) begin
          st_status_r <= plt_pkg::ST_FULL;
        end
      end
      plt_pkg::CMD_READ_POS: begin
        if (!pos_ok) begin
          st_status_r <= plt_pkg::ST_RANGE;
        end
      end
      plt_pkg::CMD_RD_DONE: begin
        st_rd_r <= rdata_r;
      end
      plt_pkg::CMD_SCAN: begin
        // On a match, the shift writes start at the matching entry
        if (hit) begin
          st_found_r <= 1'b1;
          wp_r       <= idx_r - ONE_C;
        end else if (drained) begin
          st_status_r <= plt_pkg::ST_MISSING;
        end
      end
      plt_pkg::CMD_SHIFT: begin
        if (vld_r) begin
          wp_r <= wp_r + ONE_C;
        end
      end
      plt_pkg::CMD_OUT_LOAD: begin
        out_status_r <= st_status_r;
        out_rd_r     <= st_rd_r;
        out_found_r  <= st_found_r;
        out_count_r  <= count_r;
      end
      default: begin
        op_r <= op_r;
      end
    endcase
  end

  assign out_status      = out_status_r;
  assign out_read_value  = OW'(out_rd_r);
  assign out_found       = out_found_r;
  assign out_entry_count = out_count_r;

  // Count never passes the capacity limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LIMIT_C)
    else $error("entry count above limit");

  // The shift never reads the entry it writes in the same cycle
  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (wa != ra))
    else $error("memory read and write at one address");

  // Finishing a removal drops exactly one entry
  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == plt_pkg::CMD_SHIFT && drained) |=> (count_r == $past(count_r) - ONE_C))
    else $error("removal did not drop one entry");

endmodule
